>>> rtl/core/mm4_pkg.sv
// Shared constants, types and helpers for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

	localparam int MDIM = 4;
	localparam int IDX_W = $clog2(MDIM);
	localparam int CELLS = MDIM * MDIM;
	localparam int CELL_W = $clog2(CELLS);
	localparam int BANKS = 2;
	localparam int OUTST_W = $clog2(BANKS + 1);
	localparam int MEM_DEPTH = BANKS * CELLS;
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int ELEM_W = 32;
	localparam int FRAC_W = 5;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W = PROD_W + $clog2(MDIM);
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH = 8;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
	localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd16;
	localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

	// one run handed from the load side to the compute side
	typedef struct packed {
		logic              bank;
		logic [FRAC_W-1:0] frac;
	} cmd_t;

	// store write from the load side
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [ELEM_W-1:0] left;
		logic [ELEM_W-1:0] right;
	} st_wr_t;

	// row and column ports are two bits, taken modulo four
	function automatic logic [1:0] rc2(input logic [IDX_W-1:0] idx);
		return 2'(idx);
	endfunction

endpackage

>>> rtl/core/mm4_front.sv
// Load side: element counter, bank select, fraction register and run hand-off.
module mm4_front
	import mm4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [ELEM_W-1:0] left_element,
	input  logic [ELEM_W-1:0] right_element,
	input  logic              fraction_bits_we,
	input  logic [FRAC_W-1:0] fraction_bits,
	output st_wr_t            st_wr,
	output logic              cmd_push,
	output cmd_t              cmd_new,
	input  logic              run_done
);

	logic [CELL_W-1:0]  pos_q;
	logic               bank_q;
	logic [OUTST_W-1:0] outst_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               take;
	logic               final_load;

	// both banks owned by pending or running runs: hold off loads
	assign full = (outst_q == OUTST_W'(BANKS));
	assign take = push && !full;
	assign final_load = take && (pos_q == CELL_W'(CELLS - 1));

	assign st_wr.en = take;
	assign st_wr.addr = ADDR_W'(ADDR_W'(bank_q) * ADDR_W'(CELLS) + ADDR_W'(pos_q));
	assign st_wr.left = left_element;
	assign st_wr.right = right_element;

	assign cmd_push = final_load;
	assign cmd_new.bank = bank_q;
	assign cmd_new.frac = frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bank_q <= 1'b0;
			outst_q <= '0;
			frac_q <= FRAC_RESET;
		end else begin
			if (fraction_bits_we) begin
				frac_q <= fraction_bits;
			end
			if (take) begin
				if (final_load) begin
					pos_q <= '0;
					bank_q <= !bank_q;
				end else begin
					pos_q <= pos_q + CELL_W'(1);
				end
			end
			if (final_load && !run_done) begin
				outst_q <= outst_q + OUTST_W'(1);
			end else if (run_done && !final_load) begin
				outst_q <= outst_q - OUTST_W'(1);
			end
		end
	end

	a_outst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= OUTST_W'(BANKS))
		else $error("more runs outstanding than banks");

	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |-> (outst_q != '0))
		else $error("run finished with none outstanding");

endmodule

>>> rtl/core/mm4_cmdq.sv
// Short run queue between the load side and the compute side.
module mm4_cmdq
	import mm4_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic nonempty,
	output cmd_t head
);

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_q;
	logic [CQ_PTR_W-1:0] rd_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_pop;

	assign nonempty = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_pop = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_q + CQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_q + CQ_PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CQ_CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CQ_CNT_W'(1);
			end
		end
	end

	a_cq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < CQ_CNT_W'(CQ_DEPTH)))
		else $error("run queue overflow");

endmodule

>>> rtl/core/mm4_store.sv
// Two-bank element stores for both matrices, one write and one registered read each.
module mm4_store
	import mm4_pkg::*;
(
	input  logic              clk,
	input  st_wr_t            st_wr,
	input  logic [ADDR_W-1:0] rd_left_addr,
	input  logic [ADDR_W-1:0] rd_right_addr,
	output logic [ELEM_W-1:0] left_rd,
	output logic [ELEM_W-1:0] right_rd
);

	logic [ELEM_W-1:0] left_mem_q  [MEM_DEPTH];
	logic [ELEM_W-1:0] right_mem_q [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (st_wr.en) begin
			left_mem_q[st_wr.addr] <= st_wr.left;
			right_mem_q[st_wr.addr] <= st_wr.right;
		end
		left_rd <= left_mem_q[rd_left_addr];
		right_rd <= right_mem_q[rd_right_addr];
	end

endmodule

>>> rtl/core/mm4_back.sv
// Compute side: element sequencer, multiply-accumulate pipe, shift/saturate, result queue.
module mm4_back
	import mm4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              run_done,
	output logic [ADDR_W-1:0] rd_left_addr,
	output logic [ADDR_W-1:0] rd_right_addr,
	input  logic [ELEM_W-1:0] left_rd,
	input  logic [ELEM_W-1:0] right_rd,
	output logic              empty,
	input  logic              pop,
	output logic [ELEM_W-1:0] product_element,
	output logic [1:0]        out_row,
	output logic [1:0]        out_column,
	output logic              last_of_run
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_RUN  = 2'b10
	} bk_state_t;

	typedef struct packed {
		logic              valid;
		logic              first;
		logic              lastk;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              lastrun;
		logic [FRAC_W-1:0] frac;
	} ctl_t;

	typedef struct packed {
		logic [ELEM_W-1:0] prod;
		logic [1:0]        row;
		logic [1:0]        col;
		logic              last;
	} res_t;

	bk_state_t                state_q;
	logic                     bank_q;
	logic [FRAC_W-1:0]        frac_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic [IDX_W-1:0]         k_q;
	logic [OQ_CNT_W-1:0]      rsv_q;
	logic                     issue;
	logic                     k_last;
	logic                     c_last;
	logic                     r_last;
	ctl_t                     ctl_new;
	ctl_t                     ctl_s1;
	ctl_t                     ctl_s2;
	ctl_t                     ctl_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic signed [ACC_W-1:0]  shifted_s4;
	logic                     res_valid_s4;
	logic [1:0]               row_s4;
	logic [1:0]               col_s4;
	logic                     last_s4;
	logic                     in_range;
	res_t                     res_new;
	res_t                     oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]      oq_wr_q;
	logic [OQ_PTR_W-1:0]      oq_rd_q;
	logic [OQ_CNT_W-1:0]      oq_cnt_q;
	logic                     oq_pop;
	logic                     rsv_inc;

	assign k_last = (k_q == IDX_W'(MDIM - 1));
	assign c_last = (col_q == IDX_W'(MDIM - 1));
	assign r_last = (row_q == IDX_W'(MDIM - 1));

	// an element starts only if its result has a queue slot reserved
	assign issue = (state_q == BK_RUN) && ((k_q != '0) || (rsv_q < OQ_CNT_W'(OQ_DEPTH)));
	assign rsv_inc = issue && (k_q == '0);
	assign cmd_pop = (state_q == BK_IDLE) && cmd_valid;
	assign run_done = issue && k_last && c_last && r_last;

	assign rd_left_addr = ADDR_W'(ADDR_W'(bank_q) * ADDR_W'(CELLS)
		+ ADDR_W'(row_q) * ADDR_W'(MDIM) + ADDR_W'(k_q));
	assign rd_right_addr = ADDR_W'(ADDR_W'(bank_q) * ADDR_W'(CELLS)
		+ ADDR_W'(k_q) * ADDR_W'(MDIM) + ADDR_W'(col_q));

	assign ctl_new.valid = issue;
	assign ctl_new.first = (k_q == '0);
	assign ctl_new.lastk = k_last;
	assign ctl_new.row = row_q;
	assign ctl_new.col = col_q;
	assign ctl_new.lastrun = r_last && c_last;
	assign ctl_new.frac = frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_valid) begin
						state_q <= BK_RUN;
						row_q <= '0;
						col_q <= '0;
						k_q <= '0;
					end
				end
				BK_RUN: begin
					if (issue) begin
						k_q <= k_last ? '0 : k_q + IDX_W'(1);
						if (k_last) begin
							col_q <= c_last ? '0 : col_q + IDX_W'(1);
							if (c_last) begin
								row_q <= r_last ? '0 : row_q + IDX_W'(1);
								if (r_last) begin
									state_q <= BK_IDLE;
								end
							end
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			bank_q <= cmd.bank;
			frac_q <= cmd.frac;
		end
	end

	// pipe control: read, multiply, accumulate, shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			res_valid_s4 <= 1'b0;
		end else begin
			ctl_s1 <= ctl_new;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			res_valid_s4 <= ctl_s3.valid && ctl_s3.lastk;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= $signed(left_rd) * $signed(right_rd);
		end
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_s3 <= ACC_W'(prod_s2);
			end else begin
				acc_s3 <= acc_s3 + ACC_W'(prod_s2);
			end
		end
		if (ctl_s3.valid && ctl_s3.lastk) begin
			shifted_s4 <= acc_s3 >>> ctl_s3.frac;
			row_s4 <= rc2(ctl_s3.row);
			col_s4 <= rc2(ctl_s3.col);
			last_s4 <= ctl_s3.lastrun;
		end
	end

	// fits in 32 bits when all bits above bit 30 agree
	assign in_range = (&shifted_s4[ACC_W-1:ELEM_W-1]) || !(|shifted_s4[ACC_W-1:ELEM_W-1]);
	assign res_new.prod = in_range ? shifted_s4[ELEM_W-1:0]
		: (shifted_s4[ACC_W-1] ? SAT_MIN : SAT_MAX);
	assign res_new.row = row_s4;
	assign res_new.col = col_s4;
	assign res_new.last = last_s4;

	// result queue
	assign empty = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign product_element = oq_q[oq_rd_q].prod;
	assign out_row = oq_q[oq_rd_q].row;
	assign out_column = oq_q[oq_rd_q].col;
	assign last_of_run = oq_q[oq_rd_q].last;

	always_ff @(posedge clk) begin
		if (res_valid_s4) begin
			oq_q[oq_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
			rsv_q <= '0;
		end else begin
			if (res_valid_s4) begin
				oq_wr_q <= (oq_wr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + OQ_PTR_W'(1);
			end
			if (res_valid_s4 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
			end else if (oq_pop && !res_valid_s4) begin
				oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
			end
			if (rsv_inc && !oq_pop) begin
				rsv_q <= rsv_q + OQ_CNT_W'(1);
			end else if (oq_pop && !rsv_inc) begin
				rsv_q <= rsv_q - OQ_CNT_W'(1);
			end
		end
	end

	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s4 |-> ((oq_cnt_q < OQ_CNT_W'(OQ_DEPTH)) || oq_pop))
		else $error("result queue overflow");

	a_rsv_covers: assert property (@(posedge clk) disable iff (!arst_n)
		rsv_q >= oq_cnt_q)
		else $error("result queue holds more than reserved");

endmodule

>>> rtl/core/matrix4_multiply.sv
// Top level of the 4x4 signed fixed-point matrix multiplier.
//
// Load side: drive left_element/right_element with the next row-major elements
// of A and B and raise push; a transfer happens when push is high and full is
// low. After the sixteenth transfer the pair of matrices forms one run.
// Result side: while empty is low the oldest product element is on
// product_element/out_row/out_column/last_of_run; pop transfers it. Elements
// come out in row-major order, last_of_run marks the sixteenth.
// fraction_bits_we/fraction_bits write the shift amount (reset 16); the value at
// the final load of a run applies to the whole run.
// Compute: one multiply-accumulate per cycle during a run while the result queue
// has room, four per element; loads of the next run go to the other store bank meanwhile.
// full rises while two runs are pending or running; a stalled result side fills
// the 8-entry result queue, then the compute pipe pauses at the next element boundary.
// Reset clears counters and queues; the element stores need no clearing.
module matrix4_multiply
	import mm4_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [ELEM_W-1:0] left_element,
	input  logic signed [ELEM_W-1:0] right_element,
	input  logic                     fraction_bits_we,
	input  logic [FRAC_W-1:0]        fraction_bits,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [ELEM_W-1:0] product_element,
	output logic [1:0]               out_row,
	output logic [1:0]               out_column,
	output logic                     last_of_run
);

	st_wr_t            st_wr;
	logic              cmd_push;
	cmd_t              cmd_new;
	logic              cmd_valid;
	cmd_t              cmd_head;
	logic              cmd_pop;
	logic              run_done;
	logic [ADDR_W-1:0] rd_left_addr;
	logic [ADDR_W-1:0] rd_right_addr;
	logic [ELEM_W-1:0] left_rd;
	logic [ELEM_W-1:0] right_rd;
	logic [ELEM_W-1:0] product_raw;

	mm4_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.left_element     (left_element),
		.right_element    (right_element),
		.fraction_bits_we (fraction_bits_we),
		.fraction_bits    (fraction_bits),
		.st_wr            (st_wr),
		.cmd_push         (cmd_push),
		.cmd_new          (cmd_new),
		.run_done         (run_done)
	);

	mm4_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_new),
		.pop      (cmd_pop),
		.nonempty (cmd_valid),
		.head     (cmd_head)
	);

	mm4_store u_store (
		.clk           (clk),
		.st_wr         (st_wr),
		.rd_left_addr  (rd_left_addr),
		.rd_right_addr (rd_right_addr),
		.left_rd       (left_rd),
		.right_rd      (right_rd)
	);

	mm4_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd_head),
		.cmd_pop         (cmd_pop),
		.run_done        (run_done),
		.rd_left_addr    (rd_left_addr),
		.rd_right_addr   (rd_right_addr),
		.left_rd         (left_rd),
		.right_rd        (right_rd),
		.empty           (empty),
		.pop             (pop),
		.product_element (product_raw),
		.out_row         (out_row),
		.out_column      (out_column),
		.last_of_run     (last_of_run)
	);

	assign product_element = $signed(product_raw);

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the 4x4 fixed-point matrix multiplier.
module testbench
	import mm4_pkg::*;
();

	localparam int SUM_W = 68;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 68'sh7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -68'sh8000_0000;
	localparam logic [ELEM_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam int PHASES = 8;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [ELEM_W-1:0] value;
		logic [1:0]               row;
		logic [1:0]               column;
		logic                     last;
	} product_t;

	class product_tracker;
		logic signed [ELEM_W-1:0] left_cells[CELLS];
		logic signed [ELEM_W-1:0] right_cells[CELLS];
		logic [FRAC_W-1:0]        shift;
		int                       slot;
		int unsigned              errors;
		product_t                 expected_products[$];

		function new();
			shift = FRAC_RESET;
			slot = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_products.size();
		endfunction

		task report(input string msg);
			$display("ERROR %0t: %s", $realtime, msg);
			errors++;
		endtask

		// store one load transfer; the last slot of a matrix yields the full product
		function void take_load(input logic signed [ELEM_W-1:0] a,
				input logic signed [ELEM_W-1:0] b);
			logic signed [SUM_W-1:0] acc;
			product_t p;
			left_cells[slot] = a;
			right_cells[slot] = b;
			if (slot != CELLS - 1) begin
				slot++;
				return;
			end
			slot = 0;
			for (int r = 0; r < MDIM; r++) begin
				for (int c = 0; c < MDIM; c++) begin
					acc = '0;
					for (int k = 0; k < MDIM; k++) begin
						acc = acc + longint'(left_cells[r * MDIM + k])
							* longint'(right_cells[k * MDIM + c]);
					end
					// arithmetic shift: truncates toward minus infinity
					acc = acc >>> shift;
					if (acc > SUM_MAX)
						p.value = SAT_MAX;
					else if (acc < SUM_MIN)
						p.value = SAT_MIN;
					else
						p.value = acc[ELEM_W-1:0];
					p.row = r[1:0];
					p.column = c[1:0];
					p.last = (r == MDIM - 1) && (c == MDIM - 1);
					expected_products.push_back(p);
				end
			end
		endfunction

		task check_product(input logic signed [ELEM_W-1:0] value, input logic [1:0] row,
				input logic [1:0] column, input logic last);
			product_t e;
			if (expected_products.size() == 0) begin
				report($sformatf("unexpected product %0d at (%0d,%0d)", value, row, column));
				return;
			end
			e = expected_products.pop_front();
			if (value !== e.value)
				report($sformatf("product at (%0d,%0d): got %0d, want %0d",
					e.row, e.column, value, e.value));
			if (row !== e.row)
				report($sformatf("out_row: got %0d, want %0d", row, e.row));
			if (column !== e.column)
				report($sformatf("out_column: got %0d, want %0d", column, e.column));
			if (last !== e.last)
				report($sformatf("last_of_run at (%0d,%0d): got %0b, want %0b",
					e.row, e.column, last, e.last));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic signed [ELEM_W-1:0] left_element;
	logic signed [ELEM_W-1:0] right_element;
	logic                     fraction_bits_we;
	logic [FRAC_W-1:0]        fraction_bits;
	logic                     empty;
	logic                     pop;
	logic signed [ELEM_W-1:0] product_element;
	logic [1:0]               out_row;
	logic [1:0]               out_column;
	logic                     last_of_run;

	product_tracker tracker;
	int             tx_idle_pct;
	int             rx_stall_pct;

	matrix4_multiply dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.left_element    (left_element),
		.right_element   (right_element),
		.fraction_bits_we(fraction_bits_we),
		.fraction_bits   (fraction_bits),
		.empty           (empty),
		.pop             (pop),
		.product_element (product_element),
		.out_row         (out_row),
		.out_column      (out_column),
		.last_of_run     (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("matrix4_multiply verification failed");
		$finish;
	end

	// result side: check every pop transfer, stall at the phase's rate
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				tracker.check_product(product_element, out_row, out_column, last_of_run);
			pop <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
		end
	end

	task automatic send_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		left_element <= a;
		right_element <= b;
		do @(posedge clk); while (full);
		tracker.take_load(a, b);
	endtask

	task automatic set_shift(input logic [FRAC_W-1:0] v);
		fraction_bits_we <= 1'b1;
		fraction_bits <= v;
		@(posedge clk);
		fraction_bits_we <= 1'b0;
		tracker.shift = v;
	endtask

	task automatic drain();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [ELEM_W-1:0] pick_element(input int style);
		case (style)
			0: return $urandom();
			// moderate Q16.16 values, mostly unsaturated
			1: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
			2: begin
				case ($urandom_range(0, 4))
					0: return SAT_MAX;
					1: return SAT_MIN;
					2: return '0;
					3: return ALL_ONES;
					default: return $urandom();
				endcase
			end
			default: return 32'($urandom_range(0, 15)) - 32'd8;
		endcase
	endfunction

	task automatic send_random(input int count);
		int style;
		style = 0;
		for (int i = 0; i < count; i++) begin
			if (tracker.slot == 0)
				style = $urandom_range(0, 3);
			send_pair(pick_element(style), pick_element(style));
		end
		push <= 1'b0;
	endtask

	initial begin
		logic [ELEM_W-1:0] a_dir[CELLS];
		logic [ELEM_W-1:0] b_dir[CELLS];
		int                phase_items[PHASES];
		int                phase_shift[PHASES];

		tracker = new();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		left_element <= '0;
		right_element <= '0;
		fraction_bits_we <= 1'b0;
		fraction_bits <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rows of A: all max, all min, small mix, negative/odd mix
		// every row of B: {max, min, +/-1, k+1 in Q16.16}
		for (int k = 0; k < MDIM; k++) begin
			a_dir[k] = SAT_MAX;
			a_dir[MDIM + k] = SAT_MIN;
			b_dir[k * MDIM] = SAT_MAX;
			b_dir[k * MDIM + 1] = SAT_MIN;
			b_dir[k * MDIM + 2] = k[0] ? ALL_ONES : 32'd1;
			b_dir[k * MDIM + 3] = 32'(k + 1) << 16;
		end
		a_dir[8] = '0;
		a_dir[9] = 32'd1;
		a_dir[10] = ALL_ONES;
		a_dir[11] = 32'h0001_0000;
		a_dir[12] = 32'hFFFF_0000;
		a_dir[13] = 32'h0000_8000;
		a_dir[14] = 32'd3;
		a_dir[15] = 32'hFFFF_FFF9;

		// directed matrix runs at the reset shift
		for (int i = 0; i < CELLS; i++)
			send_pair(a_dir[i], b_dir[i]);
		push <= 1'b0;
		drain();

		// phase four ends mid-matrix, so the next shift write lands between loads
		phase_items = '{48, 64, 48, 40, 56, 48, 64, 64};
		phase_shift = '{31, 0, 16, 8, 1, 30, 24, 12};
		phase_shift[5] = $urandom_range(0, 31);
		phase_shift[7] = $urandom_range(0, 31);

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 59;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 59;
				end
				default: begin
					tx_idle_pct = 6;
					rx_stall_pct = 6;
				end
			endcase
			set_shift(FRAC_W'(phase_shift[p]));
			send_random(phase_items[p]);
			drain();
		end

		if (tracker.pending() != 0)
			tracker.report("expected products left over");
		if (tracker.errors == 0)
			$display("matrix4_multiply verification clean");
		else
			$display("matrix4_multiply verification failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mm4_pkg.sv
rtl/core/mm4_front.sv
rtl/core/mm4_cmdq.sv
rtl/core/mm4_store.sv
rtl/core/mm4_back.sv
rtl/core/matrix4_multiply.sv
tb/testbench.sv
